// ===== design/sha256_stream_hasher_macros.svh =====
// Assertion macros for the SHA-256 stream hasher checker.
// No dependencies; included by files that carry assertions.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sha_pkg.sv =====
// Types, constants and round functions for the SHA-256 stream hasher.
// No dependencies.
`default_nettype none

package sha_pkg;

  typedef logic [31:0] word_t;

  localparam int DIGEST_WORDS = 8;
  localparam int WIDX_W       = 3;
  localparam int BLK_WORDS    = 16;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  localparam word_t IV [0:DIGEST_WORDS-1] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t v, input int s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch_f(input word_t x, input word_t y, input word_t z);
    ch_f = (x & y) ^ (~x & z);
  endfunction

  function automatic word_t maj_f(input word_t x, input word_t y, input word_t z);
    maj_f = (x & y) ^ (x & z) ^ (y & z);
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    unique case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== design/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: byte absorb, padding, round sequencer, digest out.
// Depends on sha_pkg.
//
//   channel | ports          | tdata          | tuser        | tlast
//   input   | in_tvalid/rdy  | data_byte[7:0] | mode         | -
//   output  | out_tvalid/rdy | digest_word    | word_index   | last_word
//
// A data byte is stored in the block buffer; the byte that fills a block starts 64 rounds
// in the shared round unit, followed by the chaining add.
// A finish runs the rounds and chaining add on the pad block, and again on a second
// block when the pad spills, then eight output requests follow.
// Reset is synchronous; chaining words load the initial hash values at once.
// in_tready is low while rounds run and while the digest is being sent.
`default_nettype none

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output sha_pkg::word_t   out_tdata,  // [31:0] digest_word
  output logic [sha_pkg::WIDX_W-1:0] out_tuser, // [2:0] word_index
  output logic             out_tlast   // last_word
);
  import sha_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] msg_r, msg_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [WIDX_W-1:0] oidx_r, oidx_nxt;
  logic        fin_r, fin_nxt;
  logic        spill_r, spill_nxt;
  word_t       chain_r [0:DIGEST_WORDS-1];
  word_t       chain_nxt [0:DIGEST_WORDS-1];
  word_t       wk_r [0:DIGEST_WORDS-1];
  word_t       wk_nxt [0:DIGEST_WORDS-1];
  word_t       w_r [0:BLK_WORDS-1];
  word_t       w_nxt [0:BLK_WORDS-1];
  word_t       w_pad [0:BLK_WORDS-1];
  word_t       t1, t2, w_new;
  logic [63:0] bit_len;
  logic        in_acc, out_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = chain_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == WIDX_W'(DIGEST_WORDS - 1));
  assign bit_len    = {msg_r, 3'b000};

  assign t1 = wk_r[7] + bsig1(wk_r[4]) + ch_f(wk_r[4], wk_r[5], wk_r[6])
            + round_k(rnd_r) + w_r[0];
  assign t2 = bsig0(wk_r[0]) + maj_f(wk_r[0], wk_r[1], wk_r[2]);
  assign w_new = w_r[0] + ssig0(w_r[1]) + w_r[9] + ssig1(w_r[14]);

  // pad block: 0x80 at the fill point, zeros after, length if it fits
  always_comb begin
    for (int j = 0; j < BLK_WORDS; j++) begin
      w_pad[j] = w_r[j];
      for (int l = 0; l < 4; l++) begin
        if (6'(4 * j + l) == fill_r) begin
          w_pad[j][31 - 8 * l -: 8] = PAD_BYTE;
        end else if (6'(4 * j + l) > fill_r) begin
          w_pad[j][31 - 8 * l -: 8] = 8'h00;
        end
      end
    end
    if (fill_r < LEN_START) begin
      w_pad[BLK_WORDS-2] = bit_len[63:32];
      w_pad[BLK_WORDS-1] = bit_len[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    msg_nxt   = msg_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    fin_nxt   = fin_r;
    spill_nxt = spill_r;
    chain_nxt = chain_r;
    wk_nxt    = wk_r;
    w_nxt     = w_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            w_nxt     = w_pad;
            wk_nxt    = chain_r;
            fin_nxt   = 1'b1;
            spill_nxt = (fill_r >= LEN_START);
            rnd_nxt   = '0;
            state_nxt = ST_ROUND;
          end else begin
            w_nxt[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] = in_tdata;
            fill_nxt = fill_r + 6'd1;
            msg_nxt  = msg_r + 61'd1;
            if (fill_r == 6'd63) begin
              wk_nxt    = chain_r;
              rnd_nxt   = '0;
              state_nxt = ST_ROUND;
            end
          end
        end
      end
      ST_ROUND: begin
        wk_nxt[0] = t1 + t2;
        wk_nxt[1] = wk_r[0];
        wk_nxt[2] = wk_r[1];
        wk_nxt[3] = wk_r[2];
        wk_nxt[4] = wk_r[3] + t1;
        wk_nxt[5] = wk_r[4];
        wk_nxt[6] = wk_r[5];
        wk_nxt[7] = wk_r[6];
        for (int j = 0; j < BLK_WORDS - 1; j++) begin
          w_nxt[j] = w_r[j + 1];
        end
        w_nxt[BLK_WORDS-1] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int j = 0; j < DIGEST_WORDS; j++) begin
          chain_nxt[j] = chain_r[j] + wk_r[j];
        end
        priority if (spill_r) begin
          for (int j = 0; j < BLK_WORDS; j++) begin
            w_nxt[j] = '0;
          end
          w_nxt[BLK_WORDS-2] = bit_len[63:32];
          w_nxt[BLK_WORDS-1] = bit_len[31:0];
          wk_nxt    = chain_nxt;
          spill_nxt = 1'b0;
          rnd_nxt   = '0;
          state_nxt = ST_ROUND;
        end else if (fin_r) begin
          oidx_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + WIDX_W'(1);
          if (out_tlast) begin
            chain_nxt = IV;
            fill_nxt  = '0;
            msg_nxt   = '0;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      msg_r   <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      spill_r <= 1'b0;
      chain_r <= IV;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      msg_r   <= msg_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      fin_r   <= fin_nxt;
      spill_r <= spill_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r <= wk_nxt;
    w_r  <= w_nxt;
  end

endmodule

`default_nettype wire

// ===== design/sha_chk.sv =====
// Port-level checker for the SHA-256 stream hasher, with its bind.
// Depends on sha_pkg and sha256_stream_hasher_macros.svh.
`default_nettype none

`include "sha256_stream_hasher_macros.svh"

module sha_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [sha_pkg::WIDX_W-1:0] out_tuser,
  input wire logic        out_tlast
);
  import sha_pkg::*;

  logic out_acc, data_acc;
  assign out_acc  = out_tvalid && out_tready;
  assign data_acc = in_tvalid && in_tready && !in_tuser;

  `SHA_ASSERT_NOW(a_no_input_while_sending, out_tvalid, !in_tready, "input taken during digest")
  `SHA_ASSERT_NOW(a_last_on_final_word, out_tvalid,
    out_tlast == (out_tuser == WIDX_W'(DIGEST_WORDS - 1)), "last flag off final word")
  `SHA_ASSERT_NEXT(a_words_in_order, out_acc && !out_tlast,
    out_tvalid && (out_tuser == WIDX_W'($past(out_tuser) + WIDX_W'(1))), "digest word skipped")
  `SHA_ASSERT_NEXT(a_done_after_last, out_acc && out_tlast, !out_tvalid, "extra digest word")
  `SHA_ASSERT_NEXT(a_data_gives_no_result, data_acc, !out_tvalid, "data byte produced a result")

endmodule

bind sha256_stream_hasher sha_chk u_sha_chk (.*);

`default_nettype wire

// ===== tb/sha256_stream_hasher_tb.sv =====
// Self-checking testbench for sha256_stream_hasher: byte messages in, digest words out.
// Keeps its own SHA-256 model and compares every digest word as it leaves the block.
// Depends on sha_pkg and the sha256_stream_hasher RTL.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;
  import sha_pkg::*;

  localparam logic MODE_DATA   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int LEN_POS   = 56;
  localparam int ITEM_GOAL = 460;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;

  localparam int IDLE_PCT  [4] = '{0, 59, 0, 38};
  localparam int STALL_PCT [4] = '{0, 0, 59, 38};
  localparam int EDGE_LEN  [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic       mode;
    logic [7:0] data;
    bit         wait_drain;
    int         phase;
  } byte_req_t;

  typedef struct {
    word_t                digest;
    logic [WIDX_W-1:0]    widx;
    logic                 lastw;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tuser = MODE_DATA;
  logic out_tvalid;
  logic out_tready = 1'b0;
  word_t out_tdata;
  logic [WIDX_W-1:0] out_tuser;
  logic out_tlast;

  byte_req_t    req_q[$];
  digest_word_t digest_q[$];

  word_t       hash_chain [8];
  logic [7:0]  pad_buf [64];
  logic [5:0]  buf_fill = '0;
  logic [60:0] msg_len = '0;

  int phase_now = 0;
  int msgs_done = 0;
  int err_cnt = 0;
  int unsigned hold_left = 0;
  bit hold_used = 1'b0;

  sha256_stream_hasher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic word_t ror32(word_t v, int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  task automatic run_rounds();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2, x, y;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {pad_buf[4*i], pad_buf[4*i+1], pad_buf[4*i+2], pad_buf[4*i+3]};
    for (i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = w[i-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[i-7] +
             (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
    end
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) +
           ROUND_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
  endtask

  // advances the hash state by one accepted request; a finish queues the digest
  task automatic absorb_request(logic mode_i, logic [7:0] byte_i);
    logic [63:0] bit_len;
    int idx;
    int k;
    if (mode_i == MODE_DATA) begin
      pad_buf[buf_fill] = byte_i;
      buf_fill = buf_fill + 6'd1;
      msg_len = msg_len + 61'd1;
      if (buf_fill == 6'd0) run_rounds();
    end else begin
      bit_len = {msg_len, 3'b000};
      idx = buf_fill;
      pad_buf[idx] = PAD_MARK;
      idx++;
      if (idx > LEN_POS) begin
        while (idx < 64) begin
          pad_buf[idx] = 8'h00;
          idx++;
        end
        run_rounds();
        idx = 0;
      end
      while (idx < LEN_POS) begin
        pad_buf[idx] = 8'h00;
        idx++;
      end
      for (k = 0; k < 8; k++) pad_buf[LEN_POS + k] = bit_len[63 - 8*k -: 8];
      run_rounds();
      for (k = 0; k < DIGEST_WORDS; k++)
        digest_q.push_back('{hash_chain[k], k[WIDX_W-1:0], (k == DIGEST_WORDS - 1)});
      hash_chain = IV;
      buf_fill = '0;
      msg_len = '0;
    end
  endtask

  task automatic add_req(logic mode_i, logic [7:0] byte_i, bit drain_i, int phase_i);
    req_q.push_back('{mode_i, byte_i, drain_i, phase_i});
  endtask

  task automatic flag_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // driver
  always @(posedge clk) begin : drv_blk
    logic fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        absorb_request(in_tuser, in_tdata);
        if (in_tuser == MODE_FINISH) msgs_done <= msgs_done + 1;
      end
      if (!in_tvalid || fire) begin
        if (req_q.size() != 0 && !(req_q[0].wait_drain && digest_q.size() != 0) &&
            $urandom_range(0, 99) >= IDLE_PCT[req_q[0].phase]) begin
          in_tvalid <= 1'b1;
          in_tuser  <= req_q[0].mode;
          in_tdata  <= req_q[0].data;
          phase_now <= req_q[0].phase;
          void'(req_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off, started after the first finish is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && msgs_done == 1) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin : mon_blk
    digest_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %h idx %0d last %b",
                                  out_tdata, out_tuser, out_tlast));
        end else begin
          want = digest_q.pop_front();
          if (out_tdata !== want.digest || out_tuser !== want.widx ||
              out_tlast !== want.lastw)
            flag_mismatch($sformatf("exp %h idx %0d last %b, got %h idx %0d last %b",
                                    want.digest, want.widx, want.lastw,
                                    out_tdata, out_tuser, out_tlast));
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= STALL_PCT[phase_now]);
    end
  end

  initial begin : stim_blk
    int len, sel, ph, i;
    bit drain;
    hash_chain = IV;
    // empty message, data byte on the finish ignored
    add_req(MODE_FINISH, 8'hff, 1'b0, 0);
    add_req(MODE_DATA, 8'h00, 1'b0, 0);
    add_req(MODE_FINISH, 8'h00, 1'b0, 0);
    add_req(MODE_DATA, 8'hff, 1'b0, 0);
    add_req(MODE_FINISH, 8'h00, 1'b0, 0);
    // "abc", held back until the earlier digests are out
    add_req(MODE_DATA, 8'h61, 1'b1, 0);
    add_req(MODE_DATA, 8'h62, 1'b0, 0);
    add_req(MODE_DATA, 8'h63, 1'b0, 0);
    add_req(MODE_FINISH, 8'h5a, 1'b0, 0);

    while (req_q.size() < ITEM_GOAL) begin
      ph = (req_q.size() * 4) / ITEM_GOAL;
      if (ph > 3) ph = 3;
      sel = $urandom_range(0, 9);
      if (sel < 4) len = $urandom_range(0, 20);
      else if (sel < 7) len = EDGE_LEN[$urandom_range(0, 7)];
      else len = $urandom_range(0, 70);
      drain = ($urandom_range(0, 5) == 0);
      for (i = 0; i < len; i++)
        add_req(MODE_DATA, 8'($urandom_range(0, 255)), drain && (i == 0), ph);
      add_req(MODE_FINISH, 8'($urandom_range(0, 255)), drain && (len == 0), ph);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_tvalid) @(negedge clk);
    while (digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0 && digest_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
